/* rtl/pol_pkg.sv */
// Shared constants, command and status codes, and cell control types for the ordered list.
`default_nettype none
package pol_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMD_W    = 3;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 7;
    localparam int ST_W     = 2;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int IN_W     = CMD_W + VAL_W + POS_W;
    localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W    = ST_W + CNT_W + VAL_W;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD = 3'd0,
        CMD_INS_TAIL = 3'd1,
        CMD_INS_POS  = 3'd2,
        CMD_DEL_POS  = 3'd3,
        CMD_READ     = 3'd4
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] ins_val;
        logic             tap_en;
    } t_cell_ctl;

endpackage
`default_nettype wire

/* rtl/pol_cell.sv */
// One list cell: holds one entry, shifts with its neighbours and taps its entry when selected.
`default_nettype none
module pol_cell (
    input  wire logic                    i_clk,
    input  wire logic [pol_pkg::IDX_W-1:0] i_index,
    input  wire pol_pkg::t_cell_ctl      i_ctl,
    input  wire logic [pol_pkg::VAL_W-1:0] i_left,
    input  wire logic [pol_pkg::VAL_W-1:0] i_right,
    output logic [pol_pkg::VAL_W-1:0]    o_val,
    output logic [pol_pkg::VAL_W-1:0]    o_tap
);

    logic [pol_pkg::VAL_W-1:0] r_val;
    logic [pol_pkg::VAL_W-1:0] n_val;
    logic [pol_pkg::VAL_W-1:0] r_tap;
    logic [pol_pkg::VAL_W-1:0] n_tap;

    always_comb begin
        n_val = r_val;
        case (i_ctl.op)
            pol_pkg::CELL_INSERT: begin
                if (i_index == i_ctl.idx) begin
                    n_val = i_ctl.ins_val;
                end else if (i_index > i_ctl.idx) begin
                    n_val = i_left;
                end
            end
            pol_pkg::CELL_DELETE: begin
                if (i_index >= i_ctl.idx) begin
                    n_val = i_right;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
        n_tap = (i_ctl.tap_en && (i_index == i_ctl.idx)) ? r_val : '0;
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_tap <= n_tap;
    end

    assign o_val = r_val;
    assign o_tap = r_tap;

endmodule
`default_nettype wire

/* rtl/positional_ordered_list_core.sv */
// Top level of the ordered list: command decode, row of cells, result gathering and output register.
// A command accepted is registered in the pending stage with its tapped entry, then the result
// is gathered over the row of cells into the output register; input waits until the result
// has left, so a new command is taken only once the result of the last one is gone.
// Reset (i_rst_n, synchronous, active low) empties the list and drops any pending result;
// the cell contents are not cleared, as no entry beyond the count is ever read.
`default_nettype none
module positional_ordered_list_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Command channel.
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata, from bit 0 up: command[2:0], value[34:3], position[41:35], zero fill.
    input  wire logic [pol_pkg::IN_BYTES_W-1:0]    s_axis_tdata,
    // Result channel.
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata, from bit 0 up: status[1:0], length[8:2], entry_value[40:9], zero fill.
    output logic [pol_pkg::OUT_BYTES_W-1:0]        m_axis_tdata
);

    // Unpacking of the incoming item.
    logic [pol_pkg::CMD_W-1:0] w_cmd;
    logic [pol_pkg::VAL_W-1:0] w_value;
    logic [pol_pkg::POS_W-1:0] w_pos;

    assign w_cmd   = s_axis_tdata[pol_pkg::CMD_W-1:0];
    assign w_value = s_axis_tdata[pol_pkg::CMD_W +: pol_pkg::VAL_W];
    assign w_pos   = s_axis_tdata[pol_pkg::CMD_W + pol_pkg::VAL_W +: pol_pkg::POS_W];

    // Control state.
    logic [pol_pkg::CNT_W-1:0] r_count;
    logic [pol_pkg::CNT_W-1:0] n_count;
    logic                      r_pend;
    logic                      r_out_valid;
    logic [pol_pkg::ST_W-1:0]  r_status;
    logic [pol_pkg::ST_W-1:0]  n_status;
    logic [pol_pkg::ST_W-1:0]  r_out_status;
    logic [pol_pkg::CNT_W-1:0] r_out_len;
    logic [pol_pkg::VAL_W-1:0] r_out_val;

    logic w_in_fire;
    logic w_out_fire;

    // A new command is taken only when no earlier one is still in flight.
    assign s_axis_tready = !r_pend && !r_out_valid;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_fire    = r_out_valid && m_axis_tready;

    // Range checks are done in a width that holds both the count plus one and any position.
    logic [pol_pkg::CMP_W-1:0] w_pos_c;
    logic [pol_pkg::CMP_W-1:0] w_cnt_c;
    logic [pol_pkg::CMP_W-1:0] w_pos_m1;
    logic                      w_full;
    logic                      w_empty;

    assign w_pos_c  = pol_pkg::CMP_W'(w_pos);
    assign w_cnt_c  = pol_pkg::CMP_W'(r_count);
    assign w_pos_m1 = w_pos_c - pol_pkg::CMP_W'(1);
    assign w_full   = (r_count >= pol_pkg::CNT_W'(pol_pkg::CAPACITY));
    assign w_empty  = (r_count == '0);

    pol_pkg::t_cell_ctl w_ctl;

    // Decode of the command into one cell operation, the status and the new count.
    always_comb begin
        w_ctl.op      = pol_pkg::CELL_HOLD;
        w_ctl.idx     = '0;
        w_ctl.ins_val = w_value;
        w_ctl.tap_en  = 1'b0;
        n_status      = pol_pkg::ST_OK;
        n_count       = r_count;
        if (w_in_fire) begin
            case (w_cmd)
                pol_pkg::CMD_INS_HEAD: begin
                    if (w_full) begin
                        n_status = pol_pkg::ST_FULL;
                    end else begin
                        w_ctl.op = pol_pkg::CELL_INSERT;
                        n_count  = r_count + pol_pkg::CNT_W'(1);
                    end
                end
                pol_pkg::CMD_INS_TAIL: begin
                    if (w_full) begin
                        n_status = pol_pkg::ST_FULL;
                    end else begin
                        w_ctl.op  = pol_pkg::CELL_INSERT;
                        w_ctl.idx = pol_pkg::IDX_W'(r_count);
                        n_count   = r_count + pol_pkg::CNT_W'(1);
                    end
                end
                pol_pkg::CMD_INS_POS: begin
                    if (w_empty) begin
                        // Into an empty list the entry goes first, whatever the position.
                        w_ctl.op = pol_pkg::CELL_INSERT;
                        n_count  = r_count + pol_pkg::CNT_W'(1);
                    end else if (w_full) begin
                        n_status = pol_pkg::ST_FULL;
                    end else if (w_pos_c == '0 ||
                                 w_pos_c > w_cnt_c + pol_pkg::CMP_W'(1)) begin
                        n_status = pol_pkg::ST_RANGE;
                    end else begin
                        w_ctl.op  = pol_pkg::CELL_INSERT;
                        w_ctl.idx = pol_pkg::IDX_W'(w_pos_m1);
                        n_count   = r_count + pol_pkg::CNT_W'(1);
                    end
                end
                pol_pkg::CMD_DEL_POS: begin
                    if (w_empty) begin
                        n_status = pol_pkg::ST_EMPTY;
                    end else if (r_count == pol_pkg::CNT_W'(1)) begin
                        // A lone entry is removed whatever the position.
                        w_ctl.op     = pol_pkg::CELL_DELETE;
                        w_ctl.tap_en = 1'b1;
                        n_count      = '0;
                    end else if (w_pos_c == '0 || w_pos_c > w_cnt_c) begin
                        n_status = pol_pkg::ST_RANGE;
                    end else begin
                        w_ctl.op     = pol_pkg::CELL_DELETE;
                        w_ctl.idx    = pol_pkg::IDX_W'(w_pos_m1);
                        w_ctl.tap_en = 1'b1;
                        n_count      = r_count - pol_pkg::CNT_W'(1);
                    end
                end
                pol_pkg::CMD_READ: begin
                    if (w_empty) begin
                        n_status = pol_pkg::ST_EMPTY;
                    end else if (w_pos_c == '0 || w_pos_c > w_cnt_c) begin
                        n_status = pol_pkg::ST_RANGE;
                    end else begin
                        w_ctl.idx    = pol_pkg::IDX_W'(w_pos_m1);
                        w_ctl.tap_en = 1'b1;
                    end
                end
                default: begin
                    // Unknown commands leave the list alone and report success.
                    n_status = pol_pkg::ST_OK;
                end
            endcase
        end
    end

    // The row of cells. Each cell takes from its left neighbour on insert and from its
    // right neighbour on delete; the end cells see their own value at the open side.
    logic [pol_pkg::VAL_W-1:0] w_val [pol_pkg::CAPACITY];
    logic [pol_pkg::VAL_W-1:0] w_tap [pol_pkg::CAPACITY];

    for (genvar g = 0; g < pol_pkg::CAPACITY; g++) begin : g_cell
        logic [pol_pkg::VAL_W-1:0] w_left;
        logic [pol_pkg::VAL_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_val[g];
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end
        if (g == pol_pkg::CAPACITY - 1) begin : g_last
            assign w_right = w_val[g];
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end

        pol_cell u_cell (
            .i_clk   (i_clk),
            .i_index (pol_pkg::IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_val   (w_val[g]),
            .o_tap   (w_tap[g])
        );
    end

    // Only the selected cell presents a nonzero tap, so the entry is an OR over the row.
    logic [pol_pkg::VAL_W-1:0] w_tap_or;

    always_comb begin
        w_tap_or = '0;
        for (int i = 0; i < pol_pkg::CAPACITY; i++) begin
            w_tap_or = w_tap_or | w_tap[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pend  <= w_in_fire;
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (w_out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_in_fire) begin
            r_status <= n_status;
        end
        if (r_pend) begin
            r_out_status <= r_status;
            r_out_len    <= r_count;
            r_out_val    <= w_tap_or;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = pol_pkg::OUT_BYTES_W'({r_out_val, r_out_len, r_out_status});

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pol_pkg::CNT_W'(pol_pkg::CAPACITY))
        else $error("list count beyond capacity");

    a_pend_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> r_out_valid)
        else $error("pending result did not reach the output register");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !r_out_valid)
        else $error("two results in flight at once");

    a_count_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_fire |=> $stable(r_count))
        else $error("count changed without an accepted command");
`endif

endmodule
`default_nettype wire

/* test/positional_ordered_list_core_checker.sv */
// Checker for the ordered list core: predicts each command's result and compares the result stream.
`timescale 1ns / 100ps
`default_nettype none
module positional_ordered_list_core_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Command channel as seen at the block.
    input  wire logic                            i_cmd_valid,
    input  wire logic                            i_cmd_ready,
    // From bit 0 up: command, value, position, zero fill.
    input  wire logic [pol_pkg::IN_BYTES_W-1:0]  i_cmd_data,
    // Result channel as seen at the block.
    input  wire logic                            i_res_valid,
    input  wire logic                            i_res_ready,
    // From bit 0 up: status, length, entry_value, zero fill.
    input  wire logic [pol_pkg::OUT_BYTES_W-1:0] i_res_data,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output logic [pol_pkg::CNT_W-1:0]            o_list_length
);

    typedef struct packed {
        pol_pkg::t_status          status;
        logic [pol_pkg::CNT_W-1:0] length;
        logic [pol_pkg::VAL_W-1:0] entry_value;
    } t_list_result;

    logic [pol_pkg::VAL_W-1:0] list_entries [pol_pkg::CAPACITY];
    int                        list_len;
    t_list_result              expected_results [$];
    int                        mismatch_count = 0;
    int                        result_index   = 0;

    // Shifts the entries up from idx and stores v there.
    function automatic void shadow_place(int idx, logic [pol_pkg::VAL_W-1:0] v);
        for (int i = list_len; i > idx; i--)
            list_entries[i] = list_entries[i-1];
        list_entries[idx] = v;
        list_len++;
    endfunction

    // Removes the entry at idx, closing the gap behind it.
    function automatic logic [pol_pkg::VAL_W-1:0] shadow_take(int idx);
        logic [pol_pkg::VAL_W-1:0] v;
        v = list_entries[idx];
        for (int i = idx; i + 1 < list_len; i++)
            list_entries[i] = list_entries[i+1];
        list_len--;
        return v;
    endfunction

    // Applies one command to the shadow list and returns the result it should give.
    function automatic t_list_result apply_list_command(logic [pol_pkg::CMD_W-1:0] cmd,
                                                        logic [pol_pkg::VAL_W-1:0] val,
                                                        logic [pol_pkg::POS_W-1:0] pos);
        t_list_result r;
        int           p;
        r = '{status: pol_pkg::ST_OK, length: '0, entry_value: '0};
        p = int'(pos);
        case (cmd)
            pol_pkg::CMD_INS_HEAD: begin
                if (list_len >= pol_pkg::CAPACITY) r.status = pol_pkg::ST_FULL;
                else shadow_place(0, val);
            end
            pol_pkg::CMD_INS_TAIL: begin
                if (list_len >= pol_pkg::CAPACITY) r.status = pol_pkg::ST_FULL;
                else shadow_place(list_len, val);
            end
            pol_pkg::CMD_INS_POS: begin
                // An empty list takes the entry whatever the position.
                if (list_len == 0) shadow_place(0, val);
                else if (list_len >= pol_pkg::CAPACITY) r.status = pol_pkg::ST_FULL;
                else if (p < 1 || p > list_len + 1) r.status = pol_pkg::ST_RANGE;
                else shadow_place(p - 1, val);
            end
            pol_pkg::CMD_DEL_POS: begin
                // A lone entry is removed whatever the position.
                if (list_len == 0) r.status = pol_pkg::ST_EMPTY;
                else if (list_len == 1) r.entry_value = shadow_take(0);
                else if (p < 1 || p > list_len) r.status = pol_pkg::ST_RANGE;
                else r.entry_value = shadow_take(p - 1);
            end
            pol_pkg::CMD_READ: begin
                if (list_len == 0) r.status = pol_pkg::ST_EMPTY;
                else if (p < 1 || p > list_len) r.status = pol_pkg::ST_RANGE;
                else r.entry_value = list_entries[p-1];
            end
            default: ;
        endcase
        r.length = pol_pkg::CNT_W'(list_len);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_list_result exp_r;
        t_list_result got_r;
        if (!i_rst_n) begin
            list_len = 0;
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got_r.status      = pol_pkg::t_status'(i_res_data[pol_pkg::ST_W-1:0]);
                got_r.length      = i_res_data[pol_pkg::ST_W +: pol_pkg::CNT_W];
                got_r.entry_value = i_res_data[pol_pkg::ST_W+pol_pkg::CNT_W +: pol_pkg::VAL_W];
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result %0d arrived with nothing outstanding: ",
                                  "status %0d length %0d value %h"},
                                 result_index, got_r.status, got_r.length,
                                 got_r.entry_value);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got_r.status !== exp_r.status || got_r.length !== exp_r.length ||
                        got_r.entry_value !== exp_r.entry_value) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result %0d: expected status %0d length %0d value %h, ",
                                      "got status %0d length %0d value %h"},
                                     result_index, exp_r.status, exp_r.length,
                                     exp_r.entry_value, got_r.status, got_r.length,
                                     got_r.entry_value);
                    end
                end
                result_index++;
            end
            if (i_cmd_valid && i_cmd_ready)
                expected_results.push_back(apply_list_command(
                    i_cmd_data[pol_pkg::CMD_W-1:0],
                    i_cmd_data[pol_pkg::CMD_W +: pol_pkg::VAL_W],
                    i_cmd_data[pol_pkg::CMD_W+pol_pkg::VAL_W +: pol_pkg::POS_W]));
        end
        o_pending     <= expected_results.size();
        o_list_length <= pol_pkg::CNT_W'(list_len);
        o_fail_count  <= mismatch_count;
    end

endmodule
`default_nettype wire

/* test/positional_ordered_list_core_tb.sv */
// Testbench top for the ordered list core: clock, reset, command stimulus, result stalls and verdict.
`timescale 1ns / 100ps
`default_nettype none
module positional_ordered_list_core_tb;

    localparam int RANDOM_ITEMS = 900;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_AFTER   = 200;
    localparam int HOLD_CYCLES  = 300;

    logic                            i_clk   = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // From bit 0 up: command, value, position, zero fill.
    logic [pol_pkg::IN_BYTES_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // From bit 0 up: status, length, entry_value, zero fill.
    logic [pol_pkg::OUT_BYTES_W-1:0] m_axis_tdata;

    int                        fail_count;
    int                        pending;
    logic [pol_pkg::CNT_W-1:0] list_length;
    int                        items_sent = 0;
    int                        burst_left = 0;
    bit                        no_gaps    = 1'b0;

    always #6 i_clk = ~i_clk;

    positional_ordered_list_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    positional_ordered_list_core_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (s_axis_tvalid),
        .i_cmd_ready   (s_axis_tready),
        .i_cmd_data    (s_axis_tdata),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_list_length (list_length)
    );

    // Offers one command, opening a gap first when the current burst is used up, and
    // returns once the block has taken it.
    task automatic send_command(logic [pol_pkg::CMD_W-1:0] cmd,
                                logic [pol_pkg::VAL_W-1:0] val,
                                logic [pol_pkg::POS_W-1:0] pos);
        int gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge i_clk) s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(pol_pkg::IN_BYTES_W-pol_pkg::IN_W){1'b0}}, pos, val, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    // Mostly ordinary values, with the sign and magnitude extremes now and then.
    function automatic logic [pol_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Result side: stall patterns drawn anew for each random span, plus one long
    // hold-off once enough commands have gone in, so that the block backs up and stops
    // taking commands.
    initial begin
        int  mode;
        int  span;
        int  phase;
        bit  held;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            mode  = $urandom_range(0, 3);
            span  = $urandom_range(50, 300);
            phase = 0;
            repeat (span) begin
                if (!held && items_sent >= HOLD_AFTER) begin
                    held = 1'b1;
                    @(negedge i_clk) m_axis_tready <= 1'b0;
                    repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                end
                @(negedge i_clk);
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (phase % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 99) < 85);
                endcase
                phase++;
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int                        r;
        int                        len;
        bit                        filling;
        logic [pol_pkg::CMD_W-1:0] cmd;
        logic [pol_pkg::POS_W-1:0] pos;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: errors on an empty list, the single-entry cases, the edges of
        // every position range, the value extremes and the unused command codes.
        send_command(pol_pkg::CMD_READ,     32'h1234_5678, 7'd1);
        send_command(pol_pkg::CMD_DEL_POS,  32'h0,         7'd5);
        send_command(pol_pkg::CMD_INS_POS,  32'h8000_0000, 7'd0);
        send_command(pol_pkg::CMD_DEL_POS,  32'h0,         7'd127);
        send_command(pol_pkg::CMD_INS_POS,  32'h7fff_ffff, 7'd127);
        send_command(pol_pkg::CMD_INS_HEAD, 32'h8000_0000, 7'd0);
        send_command(pol_pkg::CMD_INS_TAIL, 32'hffff_ffff, 7'd127);
        send_command(pol_pkg::CMD_INS_POS,  32'h1111_1111, 7'd0);
        send_command(pol_pkg::CMD_INS_POS,  32'h2222_2222, 7'd5);
        send_command(pol_pkg::CMD_INS_POS,  32'h0000_0001, 7'd4);
        send_command(pol_pkg::CMD_INS_POS,  32'h5555_aaaa, 7'd2);
        send_command(pol_pkg::CMD_INS_HEAD, 32'h0000_0000, 7'd64);
        send_command(pol_pkg::CMD_READ,     32'h0,         7'd0);
        send_command(pol_pkg::CMD_READ,     32'h0,         7'd6);
        send_command(pol_pkg::CMD_READ,     32'h0,         7'd7);
        send_command(pol_pkg::CMD_READ,     32'h0,         7'd1);
        send_command(pol_pkg::CMD_DEL_POS,  32'h0,         7'd0);
        send_command(pol_pkg::CMD_DEL_POS,  32'h0,         7'd7);
        send_command(pol_pkg::CMD_DEL_POS,  32'h0,         7'd6);
        send_command(pol_pkg::CMD_DEL_POS,  32'h0,         7'd1);
        send_command(3'd5,                  $urandom,      7'd127);
        send_command(3'd6,                  $urandom,      7'd0);
        send_command(3'd7,                  $urandom,      7'd42);
        send_command(pol_pkg::CMD_READ,     32'h0,         7'd127);

        // Random part: alternating phases that push the list towards full and then
        // back towards empty, with mostly valid positions and a little noise.
        filling = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0 && n > 0)
                filling = !filling;
            no_gaps = (n >= 400 && n < 500);
            len = int'(list_length);
            r   = $urandom_range(0, 99);
            if (r >= 95) begin
                cmd = $urandom_range(0, 1) ? pol_pkg::CMD_INS_POS :
                                             3'($urandom_range(5, 7));
                pos = pol_pkg::POS_W'($urandom_range(0, 127));
            end else begin
                if (filling)
                    cmd = (r < 70) ? 3'($urandom_range(0, 2)) :
                          (r < 85) ? pol_pkg::CMD_READ : pol_pkg::CMD_DEL_POS;
                else
                    cmd = (r < 60) ? pol_pkg::CMD_DEL_POS :
                          (r < 80) ? 3'($urandom_range(0, 2)) : pol_pkg::CMD_READ;
                if ($urandom_range(0, 9) == 0)
                    pos = pol_pkg::POS_W'($urandom_range(0, 127));
                else if (cmd == pol_pkg::CMD_INS_POS)
                    pos = pol_pkg::POS_W'($urandom_range(1, len + 1));
                else
                    pos = (len == 0) ? pol_pkg::POS_W'($urandom_range(0, 127)) :
                                       pol_pkg::POS_W'($urandom_range(1, len));
            end
            send_command(cmd, pick_value(), pos);
        end

        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("positional_ordered_list_core_tb passed");
        end else begin
            $display("positional_ordered_list_core_tb failed");
        end
        $finish;
    end

    // Watchdog, sized well beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("positional_ordered_list_core_tb failed");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
rtl/pol_pkg.sv
rtl/pol_cell.sv
rtl/positional_ordered_list_core.sv
test/positional_ordered_list_core_checker.sv
test/positional_ordered_list_core_tb.sv
